/* hdl/cfr_pkg.sv */
// Shared types and constants of the centered row FIR filter.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps

package cfr_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 17;
	localparam int RADIUS_W   = 4;
	localparam int COEF_IDX_W = 5;
	localparam int FRAC_W     = 16;
	localparam int PROD_W     = SAMPLE_W + COEF_W;

	// Item opcodes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	// Controls broadcast to every cell of the chain.
	typedef struct packed {
		logic shift_win;   // a sample enters the delay line
		logic load_work;   // copy the new window and the coefficients into the work chains
		logic shift_work;  // the work sample chain moves one cell toward the tail
		logic adv_coef;    // the work coefficient chain moves one cell toward the head
	} cell_ctl_t;

	// Controls of the multiply-accumulate unit.
	typedef struct packed {
		logic clear;   // start a new sum
		logic mul_en;  // the head pair belongs to a used tap
		logic acc_en;  // add the registered product
	} mac_ctl_t;

endpackage

/* hdl/cfr_cell.sv */
// One cell of the filter chain: a delay-line tap, a coefficient word and the work copies.
// Depends on cfr_pkg.
`timescale 1ns / 1ps

module cfr_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfr_pkg::cell_ctl_t            ctl,
	input  logic                          coef_we,
	input  logic [cfr_pkg::COEF_W-1:0]    coef_in,
	input  logic [cfr_pkg::SAMPLE_W-1:0]  win_in,
	input  logic [cfr_pkg::SAMPLE_W-1:0]  x_in,
	input  logic [cfr_pkg::COEF_W-1:0]    p_in,
	output logic [cfr_pkg::SAMPLE_W-1:0]  win,
	output logic [cfr_pkg::SAMPLE_W-1:0]  x,
	output logic [cfr_pkg::COEF_W-1:0]    p
);

	logic [cfr_pkg::SAMPLE_W-1:0] win_q;
	logic [cfr_pkg::COEF_W-1:0]   coef_q;
	logic [cfr_pkg::SAMPLE_W-1:0] x_q;
	logic [cfr_pkg::COEF_W-1:0]   p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			coef_q <= '0;
		end else begin
			if (ctl.shift_win) begin
				win_q <= win_in;
			end
			if (coef_we) begin
				coef_q <= coef_in;
			end
		end
	end

	// The work copy takes the shifted window value, which is what win_q holds next.
	always_ff @(posedge clk) begin
		if (ctl.load_work) begin
			x_q <= win_in;
			p_q <= coef_q;
		end else if (ctl.shift_work) begin
			x_q <= x_in;
			if (ctl.adv_coef) begin
				p_q <= p_in;
			end
		end
	end

	assign win = win_q;
	assign x   = x_q;
	assign p   = p_q;

endmodule

/* hdl/cfr_mac.sv */
// Multiply-accumulate unit at the head of the chain, with rounding and saturation.
// Depends on cfr_pkg.
`timescale 1ns / 1ps

module cfr_mac #(
	parameter int DEPTH = 31
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfr_pkg::mac_ctl_t             ctl,
	input  logic [cfr_pkg::SAMPLE_W-1:0]  x_head,
	input  logic [cfr_pkg::COEF_W-1:0]    p_head,
	output logic [cfr_pkg::SAMPLE_W-1:0]  result
);

	localparam int ACC_W = cfr_pkg::PROD_W + $clog2(DEPTH);

	logic [cfr_pkg::PROD_W-1:0] prod_s1;
	logic [ACC_W-1:0]           acc_q;
	logic [ACC_W:0]             rounded;
	logic [ACC_W-cfr_pkg::FRAC_W:0] scaled;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= cfr_pkg::PROD_W'(x_head) * cfr_pkg::PROD_W'(p_head);
		end else begin
			prod_s1 <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	// Round half up, drop the fraction, clamp to the sample range.
	always_comb begin
		rounded = {1'b0, acc_q} + (ACC_W+1)'(1 << (cfr_pkg::FRAC_W - 1));
		scaled  = rounded[ACC_W:cfr_pkg::FRAC_W];
		if (scaled > (ACC_W-cfr_pkg::FRAC_W+1)'({cfr_pkg::SAMPLE_W{1'b1}})) begin
			result = '1;
		end else begin
			result = scaled[cfr_pkg::SAMPLE_W-1:0];
		end
	end

endmodule

/* hdl/centered_fir_row_filter.sv */
// Centered odd-length FIR filter over image rows, built as a chain of cells.
// Depends on cfr_pkg, cfr_cell and cfr_mac.
`timescale 1ns / 1ps

// Usage:
// Items arrive on the input channel (in_valid / in_stall); a transfer happens on a clock edge
// with in_valid high and in_stall low. A load item writes one coefficient word into the cell
// that its index names; an index past the last cell is dropped. A sample item shifts the
// delay line. Once 2*radius+1 samples of the current row are held, the sample starts a pass
// that yields one result on the output channel (out_valid / out_stall).
// Load items and samples that give no result cause no input stall and can go back to back.
// A sample that gives a result stalls the input while the work chain walks all 2*MAX_RADIUS+1
// cells past the one multiply-accumulate unit at its head; then the drain state empties the
// product register into the sum, and the done state moves the rounded sum to the output register.
// A waiting result does not block the input: the next items are taken while it sits in the
// output register. If the receiver stalls long enough, the following result waits inside the
// block and the input stays stalled until the output register frees.
// The radius register is to be written through cfg_wr_en / cfg_wr_data only while the block
// is idle; the user must keep to this, as the block itself does not enforce it.
// Reset clears the delay line, the coefficients and the fill count and sets the radius to one.

module centered_fir_row_filter #(
	parameter int MAX_RADIUS = 15
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [cfr_pkg::RADIUS_W-1:0]    cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic [cfr_pkg::SAMPLE_W-1:0]    sample,
	input  logic                            row_start,
	input  logic                            row_end,
	input  logic [cfr_pkg::COEF_IDX_W-1:0]  coef_index,
	input  logic [cfr_pkg::COEF_W-1:0]      coef_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [cfr_pkg::SAMPLE_W-1:0]    filtered,
	output logic                            row_end_out
);

	localparam int DEPTH     = 2 * MAX_RADIUS + 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int STEP_W    = $clog2(DEPTH);
	localparam int RC_W      = (CNT_W > cfr_pkg::RADIUS_W) ? CNT_W : cfr_pkg::RADIUS_W;
	localparam int IDX_EXT_W = (STEP_W > cfr_pkg::COEF_IDX_W) ? STEP_W : cfr_pkg::COEF_IDX_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                         state_q, state_d;
	logic [cfr_pkg::RADIUS_W-1:0]   radius_q;
	logic [CNT_W-1:0]               fill_q;
	logic [STEP_W-1:0]              step_q;
	logic                           run_s1;
	logic                           row_end_q;
	logic                           out_valid_q;
	logic [cfr_pkg::SAMPLE_W-1:0]   filtered_q;
	logic                           row_end_out_q;

	logic                           in_xfer;
	logic                           load_xfer;
	logic                           smp_xfer;
	logic [RC_W-1:0]                rad_ext;
	logic [RC_W-1:0]                rad_cl;
	logic [CNT_W-1:0]               taps;
	logic [CNT_W-1:0]               lead;
	logic [CNT_W-1:0]               fill_base;
	logic [CNT_W-1:0]               fill_next;
	logic                           produce;
	logic                           last_step;
	logic                           in_phase;
	logic                           out_free;
	logic                           out_load;
	cfr_pkg::cell_ctl_t             cell_ctl;
	cfr_pkg::mac_ctl_t              mac_ctl;
	logic [cfr_pkg::SAMPLE_W-1:0]   result;

	logic [DEPTH-1:0]               coef_we;
	logic [cfr_pkg::SAMPLE_W-1:0]   win_chain [DEPTH];
	logic [cfr_pkg::SAMPLE_W-1:0]   x_chain   [DEPTH];
	logic [cfr_pkg::COEF_W-1:0]     p_chain   [DEPTH];

	// The input is taken only while no pass is under way.
	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign load_xfer = in_xfer && (opcode == cfr_pkg::OP_LOAD);
	assign smp_xfer  = in_xfer && (opcode == cfr_pkg::OP_SAMPLE);

	// Tap count from the radius, clamped to the size of the chain.
	always_comb begin
		rad_ext = RC_W'(radius_q);
		rad_cl  = (rad_ext > RC_W'(MAX_RADIUS)) ? RC_W'(MAX_RADIUS) : rad_ext;
		taps    = CNT_W'({rad_cl, 1'b1});
		lead    = CNT_W'(DEPTH) - taps;
	end

	// Fill count of the current row, saturating at the chain depth.
	always_comb begin
		fill_base = row_start ? '0 : fill_q;
		fill_next = (fill_base < CNT_W'(DEPTH)) ? fill_base + CNT_W'(1) : fill_base;
		produce   = (fill_next >= taps);
	end

	// During a pass the oldest sample leaves the tail of the work chain first. The first
	// DEPTH - taps steps carry ages beyond the window and add nothing; the rest pair the
	// tail sample with the coefficient at the head, tap zero first.
	assign last_step = (step_q == STEP_W'(DEPTH - 1));
	assign in_phase  = (CNT_W'(step_q) >= lead);

	always_comb begin
		cell_ctl.shift_win  = smp_xfer;
		cell_ctl.load_work  = smp_xfer && produce;
		cell_ctl.shift_work = (state_q == S_RUN);
		cell_ctl.adv_coef   = (state_q == S_RUN) && in_phase;
		mac_ctl.clear       = smp_xfer && produce;
		mac_ctl.mul_en      = (state_q == S_RUN) && in_phase;
		mac_ctl.acc_en      = run_s1;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_DONE) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (smp_xfer && produce) begin
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				if (last_step) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			radius_q    <= cfr_pkg::RADIUS_W'(1);
			fill_q      <= '0;
			step_q      <= '0;
			run_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			run_s1  <= (state_q == S_RUN);
			if (cfg_wr_en) begin
				radius_q <= cfg_wr_data;
			end
			if (smp_xfer) begin
				fill_q <= fill_next;
			end
			if (state_q == S_RUN) begin
				step_q <= last_step ? '0 : step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (smp_xfer) begin
			row_end_q <= row_end;
		end
		if (out_load) begin
			filtered_q    <= result;
			row_end_out_q <= row_end_q;
		end
	end

	// The chain: the delay line and the work samples move toward the tail, the work
	// coefficients toward the head.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [cfr_pkg::SAMPLE_W-1:0] win_in;
		logic [cfr_pkg::SAMPLE_W-1:0] x_in;
		logic [cfr_pkg::COEF_W-1:0]   p_in;

		assign coef_we[k] = load_xfer &&
			(IDX_EXT_W'(coef_index) == IDX_EXT_W'(k));

		if (k == 0) begin : g_head
			assign win_in = sample;
			assign x_in   = '0;
		end else begin : g_body
			assign win_in = win_chain[k-1];
			assign x_in   = x_chain[k-1];
		end

		if (k == DEPTH - 1) begin : g_tail
			assign p_in = '0;
		end else begin : g_inner
			assign p_in = p_chain[k+1];
		end

		cfr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (cell_ctl),
			.coef_we (coef_we[k]),
			.coef_in (coef_value),
			.win_in  (win_in),
			.x_in    (x_in),
			.p_in    (p_in),
			.win     (win_chain[k]),
			.x       (x_chain[k]),
			.p       (p_chain[k])
		);
	end

	cfr_mac #(
		.DEPTH (DEPTH)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.x_head (x_chain[DEPTH-1]),
		.p_head (p_chain[0]),
		.result (result)
	);

	assign out_valid   = out_valid_q;
	assign filtered    = filtered_q;
	assign row_end_out = row_end_out_q;

	// A result appears only when a finished pass hands it over.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result shown without a finished pass");

	// A sample that completes the window starts a pass.
	a_pass_start: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_xfer && produce) |=> (state_q == S_RUN))
		else $error("full window did not start a pass");

	// The drain cycle adds the last product and is followed by the hand-over.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> run_s1 ##1 (state_q == S_DONE))
		else $error("drain out of sequence");

	// The fill count never passes the chain depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count beyond depth");

	// A pass leaves the run state only after walking every cell.
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RUN) && !last_step) |=> (state_q == S_RUN))
		else $error("pass ended early");

endmodule

/* bench/centered_fir_row_filter_test.sv */
// Self-checking bench for centered_fir_row_filter: random and directed row traffic.
// Depends on cfr_pkg and the centered_fir_row_filter RTL; needs nothing else.
`timescale 1ns / 1ps

module centered_fir_row_filter_test;

	// The window geometry must match the instance parameter below.
	localparam int MAX_R = 15;
	localparam int DEPTH = 2 * MAX_R + 1;
	// The pause before a radius write and at the end covers a result pass still under way,
	// with some margin.
	localparam int SETTLE_CYCLES = 2 * MAX_R + 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 85;

	// One input item as it travels over the input channel.
	typedef struct packed {
		logic                           op;
		logic [cfr_pkg::SAMPLE_W-1:0]   pixel;
		logic                           first;
		logic                           last;
		logic [cfr_pkg::COEF_IDX_W-1:0] tap;
		logic [cfr_pkg::COEF_W-1:0]     weight;
	} row_item_t;

	// One filtered pixel as the output channel should carry it.
	typedef struct packed {
		logic [cfr_pkg::SAMPLE_W-1:0] level;
		logic                         last;
	} filt_out_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [cfr_pkg::RADIUS_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_stall;
	logic out_valid;
	logic out_stall;
	logic [cfr_pkg::SAMPLE_W-1:0] filtered;
	logic row_end_out;
	row_item_t cur_item;

	// Items waiting to be offered, and filtered pixels still owed by the block.
	row_item_t pending_q[$];
	filt_out_t owed_q[$];

	// Private copy of the filter state, advanced once per accepted transfer.
	logic [cfr_pkg::SAMPLE_W-1:0] win_mem[DEPTH];
	logic [cfr_pkg::COEF_W-1:0] coef_mem[DEPTH];
	int fill_cnt;
	logic [cfr_pkg::RADIUS_W-1:0] radius_cur;

	// Handshake bookkeeping of the driver, the receiver and the monitor, and the watchdog's cycle count.
	bit in_taken;
	bit send_calm;
	bit recv_calm;
	int send_gap;
	int stall_left;
	int fault_count;
	int cycle_count;
	filt_out_t due;

	always #5 clk = ~clk;

	centered_fir_row_filter #(
		.MAX_RADIUS(MAX_R)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(cur_item.op),
		.sample(cur_item.pixel),
		.row_start(cur_item.first),
		.row_end(cur_item.last),
		.coef_index(cur_item.tap),
		.coef_value(cur_item.weight),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered(filtered),
		.row_end_out(row_end_out)
	);

	// Number of taps in use; the radius is clamped to the window the block was built with.
	function automatic int cur_taps();
		int r;
		r = (radius_cur > MAX_R) ? MAX_R : int'(radius_cur);
		return 2 * r + 1;
	endfunction

	// Idle length for either side: mostly none or short, now and then long. While a side is
	// in a calm stretch it never idles.
	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance the filter copy by one accepted item and record the pixel it must produce.
	// Tap 0 pairs with the oldest sample of the window and the last tap with the newest.
	task automatic apply_item(input row_item_t it);
		logic [63:0] acc;
		logic [63:0] rounded;
		logic [63:0] px64;
		logic [63:0] wt64;
		int taps;
		filt_out_t res;
		if (it.op == cfr_pkg::OP_LOAD) begin
			// A load beyond the last tap position is dropped.
			if (it.tap < DEPTH)
				coef_mem[it.tap] = it.weight;
			return;
		end
		if (it.first)
			fill_cnt = 0;
		for (int i = DEPTH - 1; i > 0; i--)
			win_mem[i] = win_mem[i - 1];
		win_mem[0] = it.pixel;
		if (fill_cnt < DEPTH)
			fill_cnt++;
		taps = cur_taps();
		// Until the window holds enough samples of this row, nothing comes out and any
		// row end mark on the sample is lost.
		if (fill_cnt < taps)
			return;
		acc = '0;
		for (int t = 0; t < taps; t++) begin
			px64 = 64'(win_mem[taps - 1 - t]);
			wt64 = 64'(coef_mem[t]);
			acc = acc + px64 * wt64;
		end
		// Round half up at the Q.16 point, then clip to the 16-bit pixel range.
		rounded = (acc + 64'h8000) >> cfr_pkg::FRAC_W;
		res.level = (rounded > 64'hFFFF) ? 16'hFFFF : rounded[15:0];
		res.last = it.last;
		owed_q.push_back(res);
	endtask

	task automatic push_sample(input logic [15:0] px, input logic first, input logic last);
		row_item_t it;
		it = '0;
		it.op = cfr_pkg::OP_SAMPLE;
		it.pixel = px;
		it.first = first;
		it.last = last;
		pending_q.push_back(it);
	endtask

	task automatic push_load(input logic [4:0] idx, input logic [16:0] val);
		row_item_t it;
		it = '0;
		it.op = cfr_pkg::OP_LOAD;
		it.tap = idx;
		it.weight = val;
		pending_q.push_back(it);
	endtask

	function automatic logic [15:0] pick_pixel();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'h0000;
		if (r < 20)
			return 16'hFFFF;
		return 16'($urandom_range(0, 65535));
	endfunction

	// Most weights sit around unity gain for the window, so results stay mostly inside
	// the pixel range; the extremes still show up often enough to force clipping.
	function automatic logic [16:0] pick_weight(input int taps);
		int r;
		int hi;
		r = $urandom_range(0, 99);
		hi = 131072 / taps;
		if (hi > 65536)
			hi = 65536;
		if (r < 8)
			return 17'h00000;
		if (r < 16)
			return 17'h10000;
		if (r < 36)
			return 17'($urandom_range(0, 65536));
		return 17'($urandom_range(0, hi));
	endfunction

	function automatic logic [4:0] pick_index();
		if ($urandom_range(0, 19) == 0)
			return 5'd31;
		return 5'($urandom_range(0, DEPTH - 1));
	endfunction

	// Mostly complete rows with random content, some rows too short to fill the window,
	// some with a missing start or end mark, and a sprinkling of loads and pure noise.
	task automatic random_rows(input int budget);
		int made;
		int kind;
		int len;
		int taps;
		int n;
		row_item_t it;
		taps = cur_taps();
		made = 0;
		while (made < budget) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				it.op = 1'($urandom_range(0, 1));
				it.pixel = 16'($urandom_range(0, 65535));
				it.first = 1'($urandom_range(0, 1));
				it.last = 1'($urandom_range(0, 1));
				it.tap = 5'($urandom_range(0, 31));
				it.weight = 17'($urandom_range(0, 65536));
				pending_q.push_back(it);
				made++;
			end else if (kind < 18) begin
				n = $urandom_range(1, 3);
				repeat (n) push_load(pick_index(), pick_weight(taps));
				made += n;
			end else begin
				if ($urandom_range(0, 6) == 0)
					len = $urandom_range(1, taps);
				else
					len = taps + $urandom_range(0, 12);
				for (int k = 0; k < len; k++)
					push_sample(pick_pixel(), k == 0 && $urandom_range(0, 9) != 0,
						k == len - 1 && $urandom_range(0, 9) != 0);
				made += len;
			end
		end
	endtask

	// Wait until every item went over and every owed pixel came back, then let the block
	// finish any pass still in flight.
	task automatic wait_idle();
		while (pending_q.size() != 0 || in_valid || owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Drive one radius write through cfg_wr_en / cfg_wr_data and update the bench copy of the radius.
	task automatic write_radius(input logic [3:0] r);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		radius_cur = r;
	endtask

	// Input driver. A new item is offered only when the channel is empty or the last one
	// was transferred at the preceding rising edge; a stalled item stays put. When items
	// follow back to back, in_valid simply stays high.
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			send_calm = !send_calm;
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				cur_item <= pending_q.pop_front();
				in_valid <= 1'b1;
				send_gap = pick_gap(send_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output receiver: stalls of random length, independent of out_valid.
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			recv_calm = !recv_calm;
		if (stall_left == 0)
			stall_left = pick_gap(recv_calm);
		out_stall <= (stall_left > 0);
		if (stall_left > 0)
			stall_left--;
	end

	// Monitor. Both channels are sampled at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			apply_item(cur_item);
			in_taken = 1'b1;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (owed_q.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, actual filtered %h row_end_out %b",
					$time, filtered, row_end_out);
				fault_count++;
			end else begin
				due = owed_q.pop_front();
				if (filtered !== due.level) begin
					$display("%0t: filtered mismatch, expected %h, actual %h",
						$time, due.level, filtered);
					fault_count++;
				end
				if (row_end_out !== due.last) begin
					$display("%0t: row_end_out mismatch, expected %b, actual %b",
						$time, due.last, row_end_out);
					fault_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("centered_fir_row_filter_test: FAIL");
		$finish;
	end

	initial begin
		logic [3:0] radius_plan[$];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		cur_item = '0;
		in_taken = 1'b0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		send_gap = 0;
		stall_left = 0;
		fault_count = 0;
		radius_cur = 4'd1;
		fill_cnt = 0;
		for (int i = 0; i < DEPTH; i++) begin
			win_mem[i] = '0;
			coef_mem[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset radius of one (three taps).
		// A row end on a sample that cannot fill the window is dropped, and with all
		// coefficients still zero the first result is zero.
		push_sample(16'hFFFF, 1'b1, 1'b1);
		push_sample(16'h0000, 1'b0, 1'b0);
		push_sample(16'h1234, 1'b0, 1'b0);
		// Full-scale weights, one load past the last tap that must be ignored, and the
		// top tap position; then full-scale pixels drive the sum into clipping.
		push_load(5'd0, 17'h10000);
		push_load(5'd1, 17'h10000);
		push_load(5'd2, 17'h10000);
		push_load(5'd31, 17'h0ABCD);
		push_load(5'd30, 17'h10000);
		push_sample(16'hFFFF, 1'b0, 1'b0);
		push_sample(16'hFFFF, 1'b0, 1'b1);
		// A single weight of one LSB on the center tap checks rounding: half an LSB
		// rounds up, just under half rounds down.
		push_load(5'd0, 17'h00000);
		push_load(5'd1, 17'h00001);
		push_load(5'd2, 17'h00000);
		push_sample(16'h8000, 1'b1, 1'b0);
		push_sample(16'h8000, 1'b0, 1'b1);
		push_sample(16'h8000, 1'b0, 1'b0);
		push_sample(16'h7FFF, 1'b0, 1'b0);
		push_sample(16'h7FFF, 1'b0, 1'b1);
		// A new row, then samples without a start mark that keep filling it.
		push_sample(16'h5555, 1'b1, 1'b0);
		push_sample(16'hAAAA, 1'b0, 1'b0);
		push_sample(16'h1111, 1'b0, 1'b1);
		wait_idle();

		// Random phases over several radii, the extremes first. Each phase opens with a few
		// samples that carry on the previous row, so a radius change meets a window that is
		// already partly or fully held.
		radius_plan = '{4'd0, 4'd15, 4'd8, 4'd5, 4'd1};
		radius_plan.push_back(4'($urandom_range(0, 15)));
		radius_plan.push_back(4'($urandom_range(0, 15)));
		foreach (radius_plan[p]) begin
			write_radius(radius_plan[p]);
			repeat (3) push_sample(pick_pixel(), 1'b0, 1'($urandom_range(0, 1)));
			for (int t = 0; t < cur_taps(); t++)
				push_load(5'(t), pick_weight(cur_taps()));
			random_rows(PHASE_ITEMS);
			wait_idle();
		end

		if (fault_count == 0)
			$display("centered_fir_row_filter_test: PASS");
		else
			$display("centered_fir_row_filter_test: FAIL");
		$finish;
	end

endmodule

/* sim.f */
hdl/cfr_pkg.sv
hdl/cfr_cell.sv
hdl/cfr_mac.sv
hdl/centered_fir_row_filter.sv
bench/centered_fir_row_filter_test.sv
